// File: src/fmr_pkg.sv
// Package for the framed message receiver: frame layout constants and shared types.
// No dependencies; used by every module of the receiver.
`timescale 1ns / 1ps

package fmr_pkg;

    localparam int PAYLOAD_BYTES_DEF = 8;
    localparam int PAYLOAD_MAX       = 8;
    localparam int HEADER_COUNT      = 5;
    localparam int PAYLOAD_FIRST_POS = 6;
    localparam int POS_W             = 4;
    localparam int BYTE_W            = 8;

    // result field layout inside m_axis_tdata, lowest bit first
    localparam int PRIO_LSB  = 0;
    localparam int EE_BIT    = 3;
    localparam int RW_BIT    = 4;
    localparam int REM_BIT   = 5;
    localparam int KIND_LSB  = 6;
    localparam int CMD_LSB   = 14;
    localparam int DEST_LSB  = 22;
    localparam int LEN_LSB   = 30;
    localparam int PL_LSB    = 34;
    localparam int PL_W      = 64;
    localparam int FIELDS_W  = PL_LSB + PL_W;
    localparam int TDATA_W   = ((FIELDS_W + 7) / 8) * 8;

    typedef struct packed {
        logic                  valid;
        logic [BYTE_W-1:0]     data;
    } byte_beat_t;

endpackage

// File: src/fmr_in_stage.sv
// Input register stage of the framed message receiver.
// Depends on fmr_pkg for the byte transfer type.
`timescale 1ns / 1ps

module fmr_in_stage
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [fmr_pkg::BYTE_W-1:0]        in_data,
    input  logic                              advance,
    output fmr_pkg::byte_beat_t               beat
);

    logic                          valid_reg;
    logic                          valid_next;
    logic [fmr_pkg::BYTE_W-1:0]    data_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // hold the byte until the assembler takes it
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= in_data;
        end
    end

    assign beat.valid = valid_reg;
    assign beat.data  = data_reg;

endmodule

// File: src/fmr_assembler.sv
// Frame assembler: start hunting, header and payload capture, checksum and result register.
// Depends on fmr_pkg for layout constants and the byte transfer type.
`timescale 1ns / 1ps

module fmr_assembler
#(
    parameter int PAYLOAD_BYTES = fmr_pkg::PAYLOAD_BYTES_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start_byte_we,
    input  logic [fmr_pkg::BYTE_W-1:0]        start_byte_wdata,
    input  fmr_pkg::byte_beat_t               beat,
    output logic                              advance,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [fmr_pkg::TDATA_W-1:0]       out_data,
    output logic                              out_ok
);

    localparam logic [fmr_pkg::POS_W-1:0] CHK_POS =
        fmr_pkg::POS_W'(fmr_pkg::PAYLOAD_FIRST_POS + PAYLOAD_BYTES);

    logic [fmr_pkg::BYTE_W-1:0]   start_reg;
    logic [fmr_pkg::POS_W-1:0]    pos_reg;
    logic [fmr_pkg::POS_W-1:0]    pos_next;
    logic [fmr_pkg::BYTE_W-1:0]   sum_reg;
    logic [fmr_pkg::BYTE_W-1:0]   sum_next;
    logic [fmr_pkg::BYTE_W-1:0]   hdr_reg [fmr_pkg::HEADER_COUNT];
    logic [fmr_pkg::BYTE_W-1:0]   pl_reg  [PAYLOAD_BYTES];
    logic                         valid_reg;
    logic                         valid_next;
    logic [fmr_pkg::TDATA_W-1:0]  data_reg;
    logic [fmr_pkg::TDATA_W-1:0]  data_next;
    logic                         ok_reg;
    logic                         take;
    logic                         emit;
    logic [fmr_pkg::PL_W-1:0]     pl_word;

    // only the checksum byte waits for a free result register
    assign advance = !valid_reg || out_ready || (pos_reg != CHK_POS);
    assign take    = beat.valid && advance;
    assign emit    = take && (pos_reg == CHK_POS);

    always_comb
    begin
        pos_next = pos_reg;
        sum_next = sum_reg;
        if (take)
        begin
            if (pos_reg == '0)
            begin
                if (beat.data == start_reg)
                begin
                    sum_next = beat.data;
                    pos_next = fmr_pkg::POS_W'(1);
                end
            end
            else if (pos_reg == CHK_POS)
            begin
                sum_next = '0;
                pos_next = '0;
            end
            else
            begin
                sum_next = sum_reg + beat.data;
                pos_next = pos_reg + fmr_pkg::POS_W'(1);
            end
        end
    end

    always_comb
    begin
        pl_word = '0;
        for (int i = 0; i < PAYLOAD_BYTES; i++)
        begin
            pl_word[i*fmr_pkg::BYTE_W +: fmr_pkg::BYTE_W] = pl_reg[i];
        end
    end

    always_comb
    begin
        data_next = '0;
        data_next[fmr_pkg::PRIO_LSB +: 3] = hdr_reg[0][7:5];
        data_next[fmr_pkg::EE_BIT]        = hdr_reg[0][4];
        data_next[fmr_pkg::RW_BIT]        = hdr_reg[0][3];
        data_next[fmr_pkg::REM_BIT]       = hdr_reg[0][0];
        data_next[fmr_pkg::KIND_LSB +: 8] = hdr_reg[1];
        data_next[fmr_pkg::CMD_LSB +: 8]  = hdr_reg[2];
        data_next[fmr_pkg::DEST_LSB +: 8] = hdr_reg[3];
        data_next[fmr_pkg::LEN_LSB +: 4]  = hdr_reg[4][7:4];
        data_next[fmr_pkg::PL_LSB +: fmr_pkg::PL_W] = pl_word;
    end

    assign valid_next = emit ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            pos_reg   <= '0;
            sum_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (start_byte_we)
            begin
                start_reg <= start_byte_wdata;
            end
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
            valid_reg <= valid_next;
        end
    end

    // capture header and payload bytes at their frame positions
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            for (int i = 0; i < fmr_pkg::HEADER_COUNT; i++)
            begin
                if (pos_reg == fmr_pkg::POS_W'(i + 1))
                begin
                    hdr_reg[i] <= beat.data;
                end
            end
            for (int i = 0; i < PAYLOAD_BYTES; i++)
            begin
                if (pos_reg == fmr_pkg::POS_W'(fmr_pkg::PAYLOAD_FIRST_POS + i))
                begin
                    pl_reg[i] <= beat.data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            data_reg <= data_next;
            ok_reg   <= (beat.data == sum_reg);
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_ok    = ok_reg;

endmodule

// File: src/framed_message_receiver_unit.sv
// Top level of the framed message receiver: input stage plus frame assembler.
// Depends on fmr_pkg, fmr_in_stage and fmr_assembler.
//
// Usage:
//   s_axis carries one received link byte per transfer in tdata[7:0].
//   While hunting, bytes that differ from the start byte register are dropped;
//   a match opens a frame of 7 + PAYLOAD_BYTES bytes (start, flags, type,
//   command, destination, length, payload, checksum).
//   On the checksum byte one result leaves on m_axis: decoded fields in tdata,
//   checksum_ok in tuser. Frames with a bad checksum are still delivered.
//   start_byte_we / start_byte_wdata write the start byte register.
// Timing:
//   One byte per cycle sustained unless a stalled m_axis holds s_axis back. A result
//   follows its checksum byte through the input register, then the result register.
//   A stalled m_axis holds its result; s_axis keeps taking bytes until the
//   next checksum byte waits in the input register behind it, then tready drops.
// Reset:
//   rst_n clears the start byte to zero, returns to hunting and empties both
//   registers.
`timescale 1ns / 1ps

module framed_message_receiver_unit
#(
    parameter int PAYLOAD_BYTES = fmr_pkg::PAYLOAD_BYTES_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start_byte_we,
    input  logic [7:0]                        start_byte_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // rx_byte
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // priority_res[2:0], eeprom_ram[3], read_write[4], remote[5], msg_kind[13:6],
    // command[21:14], destination[29:22], data_length[33:30], payload[97:34], zeros
    output logic [fmr_pkg::TDATA_W-1:0]       m_axis_tdata,
    output logic                              m_axis_tuser   // checksum_ok
);

    fmr_pkg::byte_beat_t beat;
    logic                advance;

    fmr_in_stage u_in_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_data  (s_axis_tdata),
        .advance  (advance),
        .beat     (beat)
    );

    fmr_assembler #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_assembler
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .start_byte_we    (start_byte_we),
        .start_byte_wdata (start_byte_wdata),
        .beat             (beat),
        .advance          (advance),
        .out_valid        (m_axis_tvalid),
        .out_ready        (m_axis_tready),
        .out_data         (m_axis_tdata),
        .out_ok           (m_axis_tuser)
    );

endmodule

// File: src/fmr_checker.sv
// Port-level checker for the framed message receiver, bound to the top level.
// Depends on fmr_pkg for the result width.
`timescale 1ns / 1ps

module fmr_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [fmr_pkg::TDATA_W-1:0]       m_axis_tdata,
    input  logic                              m_axis_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with no result waiting");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without a checksum byte two cycles earlier");

endmodule

bind framed_message_receiver_unit fmr_checker u_fmr_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
